FILE: hdl/mcn_pkg.sv
// Shared types, constants and calendar helper functions for the month calendar navigator.
`timescale 1ns / 1ps
`default_nettype none

package mcn_pkg;

  localparam int KIND_W     = 3;
  localparam int YEAR_W     = 12;
  localparam int MONTH_W    = 4;
  localparam int DAY_W      = 5;
  localparam int GRID_W     = 3;
  localparam int WD_W       = 3;
  localparam int PDAY_W     = 6;
  localparam int YEAR_SUM_W = 13;
  localparam int ADDR_W     = 6;

  localparam logic [KIND_W-1:0] KIND_GOTO   = 3'd0;
  localparam logic [KIND_W-1:0] KIND_NDAY   = 3'd1;
  localparam logic [KIND_W-1:0] KIND_NMONTH = 3'd2;
  localparam logic [KIND_W-1:0] KIND_PMONTH = 3'd3;
  localparam logic [KIND_W-1:0] KIND_NYEAR  = 3'd4;
  localparam logic [KIND_W-1:0] KIND_SELECT = 3'd5;

  localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
  localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
  localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;
  localparam logic [DAY_W-1:0]   DAY_ONE   = 5'd1;
  localparam logic [PDAY_W-1:0]  PDAY_ONE  = 6'd1;
  localparam logic [DAY_W-1:0]   LONG_MONTH = 5'd31;
  localparam logic [DAY_W-1:0]   LEAP_FEB  = 5'd29;
  localparam logic [GRID_W-1:0]  ROW_LAST  = 3'd5;
  localparam logic [GRID_W-1:0]  COL_LAST  = 3'd6;

  localparam logic [DAY_W-1:0] BASE_LEN [12] = '{
    5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
    5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
  };

  typedef logic [ADDR_W-1:0] addr_t;

  typedef enum logic [4:0] {
    OP_NOP,
    OP_FETCH,
    OP_EMIT,
    OP_GOTO,
    OP_DAY_INC,
    OP_NM_DAY1,
    OP_NMONTH,
    OP_PMONTH,
    OP_NYEAR,
    OP_CELL,
    OP_PICK_CELL,
    OP_PICK_PREV,
    OP_PICK_NEXT_DAY,
    OP_PICK_YM,
    OP_FIX_DAY,
    OP_WALK_INIT,
    OP_YEAR_STEP,
    OP_MONTH_STEP,
    OP_FINISH
  } uop_t;

  typedef enum logic [3:0] {
    C_ALWAYS,
    C_NO_ITEM,
    C_OUT_BLOCKED,
    C_DAY_FITS,
    C_NM_BLOCK,
    C_PM_BLOCK,
    C_NY_BLOCK,
    C_CELL_OFF,
    C_CELL_BEFORE,
    C_CELL_AFTER,
    C_YEAR_MORE,
    C_MONTH_MORE
  } cond_t;

  typedef enum logic [2:0] {
    SQ_NEXT,
    SQ_COND,
    SQ_CALL,
    SQ_RET,
    SQ_DISPATCH
  } seq_t;

  typedef struct packed {
    uop_t  op;
    seq_t  mode;
    cond_t cond;
    addr_t target;
  } ctl_t;

  typedef struct packed {
    logic day_fits;
    logic nm_block;
    logic pm_block;
    logic ny_block;
    logic cell_off;
    logic cell_before;
    logic cell_after;
    logic year_more;
    logic month_more;
  } stat_t;

  typedef struct packed {
    logic                accepted;
    logic [YEAR_W-1:0]   view_year;
    logic [MONTH_W-1:0]  view_month;
    logic [DAY_W-1:0]    view_day;
    logic [WD_W-1:0]     first_weekday;
    logic [DAY_W-1:0]    month_length;
    logic [DAY_W-1:0]    prior_month_length;
    logic [YEAR_W-1:0]   chosen_year;
    logic [MONTH_W-1:0]  chosen_month;
    logic [PDAY_W-1:0]   chosen_day;
  } res_t;

  function automatic logic [DAY_W-1:0] mlen(input logic [MONTH_W-1:0] m, input logic lp);
    logic [DAY_W-1:0] r;
    if (m == '0 || m > MONTH_DEC) begin
      r = LONG_MONTH;
    end else if (m == MONTH_FEB && lp) begin
      r = LEAP_FEB;
    end else begin
      r = BASE_LEN[m - MONTH_JAN];
    end
    return r;
  endfunction

  function automatic logic [WD_W-1:0] mod7(input logic [5:0] x);
    logic [5:0] v;
    v = x;
    if (v >= 6'd56) v = v - 6'd56;
    if (v >= 6'd28) v = v - 6'd28;
    if (v >= 6'd14) v = v - 6'd14;
    if (v >= 6'd7)  v = v - 6'd7;
    return v[WD_W-1:0];
  endfunction

  function automatic logic leap(input logic [1:0] m4, input logic [6:0] m100,
                                input logic [8:0] m400);
    logic r;
    if (m100 == '0) begin
      r = (m400 == '0);
    end else begin
      r = (m4 == '0);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: hdl/month_calendar_navigator_core.sv
// Top level of the month calendar navigator: stream ports, output register, sequencer and datapath.
//
// Usage:
//   The slave stream takes one command item at a time (kind in s_tuser; target date and grid
//   cell in s_tdata). The master stream returns one result item per command: the accepted flag
//   in m_tuser, and the viewed date, month layout and selected date in m_tdata.
//   A microprogram runs each command. Plain moves (next day within the month, cell inside the
//   month) return a result without a calendar walk. Any move that changes the viewed month
//   walks the calendar from January of FIRST_YEAR, one year per cycle and then one month
//   per cycle. That year walk sets the throughput.
//   s_tready is high only while the sequencer waits for a command; the next command can be taken
//   in the cycle after the result is loaded into the output register.
//   The output register holds a result until m_tready; while it is full and stalled, a new
//   result waits in the sequencer and no further command is taken.
//   Reset (rst, synchronous) views and selects January 1 of FIRST_YEAR with its month layout
//   ready at once, and empties the output register.
`timescale 1ns / 1ps
`default_nettype none

module month_calendar_navigator_core import mcn_pkg::*; #(
  parameter int FIRST_YEAR = 1990,
  parameter int YEAR_SPAN  = 128
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // year[11:0], month[15:12], day[20:16], row[23:21],
                                 // column[26:24], zero[31:27]
  input  logic [2:0]  s_tuser,   // kind[2:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [55:0] m_tdata,   // view_year[11:0], view_month[15:12], view_day[20:16],
                                 // first_weekday[23:21], month_length[28:24],
                                 // prior_month_length[33:29], chosen_year[45:34],
                                 // chosen_month[49:46], chosen_day[55:50]
  output logic [0:0]  m_tuser    // accepted[0]
);

  uop_t              op;
  stat_t             stat;
  res_t              res;
  logic [KIND_W-1:0] kind;
  logic              in_fire;
  logic              out_blocked;
  logic              emit_load;

  assign s_tready    = (op == OP_FETCH);
  assign in_fire     = s_tvalid && s_tready;
  assign out_blocked = m_tvalid && !m_tready;
  assign emit_load   = (op == OP_EMIT) && !out_blocked;

  mcn_seq u_seq (
    .clk         (clk),
    .rst         (rst),
    .stat        (stat),
    .no_item     (!s_tvalid),
    .out_blocked (out_blocked),
    .kind        (kind),
    .op          (op)
  );

  mcn_dp #(
    .FIRST_YEAR (FIRST_YEAR),
    .YEAR_SPAN  (YEAR_SPAN)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .op        (op),
    .in_fire   (in_fire),
    .in_kind   (s_tuser),
    .in_year   (s_tdata[11:0]),
    .in_month  (s_tdata[15:12]),
    .in_day    (s_tdata[20:16]),
    .in_row    (s_tdata[23:21]),
    .in_column (s_tdata[26:24]),
    .kind      (kind),
    .stat      (stat),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (emit_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_load) begin
      m_tdata <= {res.chosen_day, res.chosen_month, res.chosen_year,
                  res.prior_month_length, res.month_length, res.first_weekday,
                  res.view_day, res.view_month, res.view_year};
      m_tuser <= res.accepted;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/mcn_seq.sv
// Microprogram sequencer: control store, step counter, return register and dispatch.
`timescale 1ns / 1ps
`default_nettype none

module mcn_seq import mcn_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  stat_t             stat,
  input  logic              no_item,
  input  logic              out_blocked,
  input  logic [KIND_W-1:0] kind,
  output uop_t              op
);

  localparam addr_t A_EMIT     = 6'd0;
  localparam addr_t A_FETCH    = 6'd1;
  localparam addr_t A_DISPATCH = 6'd2;
  localparam addr_t A_GOTO     = 6'd3;
  localparam addr_t A_GOTO_END = 6'd4;
  localparam addr_t A_NDAY     = 6'd5;
  localparam addr_t A_NDAY_CHK = 6'd6;
  localparam addr_t A_NDAY_ADV = 6'd7;
  localparam addr_t A_NDAY_END = 6'd8;
  localparam addr_t A_NDAY_INC = 6'd9;
  localparam addr_t A_NMON     = 6'd10;
  localparam addr_t A_NMON_GO  = 6'd11;
  localparam addr_t A_PMON     = 6'd12;
  localparam addr_t A_PMON_GO  = 6'd13;
  localparam addr_t A_NYEAR    = 6'd14;
  localparam addr_t A_NYEAR_GO = 6'd15;
  localparam addr_t A_FIXUP    = 6'd16;
  localparam addr_t A_FIXUP_FD = 6'd17;
  localparam addr_t A_SEL      = 6'd18;
  localparam addr_t A_SEL_CELL = 6'd19;
  localparam addr_t A_SEL_BEF  = 6'd20;
  localparam addr_t A_SEL_AFT  = 6'd21;
  localparam addr_t A_SEL_HERE = 6'd22;
  localparam addr_t A_SPREV    = 6'd23;
  localparam addr_t A_SPREV_MV = 6'd24;
  localparam addr_t A_SPREV_FD = 6'd25;
  localparam addr_t A_SPREV_PK = 6'd26;
  localparam addr_t A_SNEXT    = 6'd27;
  localparam addr_t A_SNEXT_PD = 6'd28;
  localparam addr_t A_SNEXT_MV = 6'd29;
  localparam addr_t A_SNEXT_FD = 6'd30;
  localparam addr_t A_SNEXT_PK = 6'd31;
  localparam addr_t A_RECOMP   = 6'd32;
  localparam addr_t A_WALK_Y   = 6'd33;
  localparam addr_t A_WALK_M   = 6'd34;
  localparam addr_t A_FINISH   = 6'd35;

  function automatic ctl_t rom(input addr_t a);
    ctl_t w;
    unique case (a)
      A_EMIT:     w = ctl_t'{OP_EMIT,          SQ_COND,     C_OUT_BLOCKED, A_EMIT};
      A_FETCH:    w = ctl_t'{OP_FETCH,         SQ_COND,     C_NO_ITEM,     A_FETCH};
      A_DISPATCH: w = ctl_t'{OP_NOP,           SQ_DISPATCH, C_ALWAYS,      A_EMIT};
      A_GOTO:     w = ctl_t'{OP_GOTO,          SQ_CALL,     C_ALWAYS,      A_RECOMP};
      A_GOTO_END: w = ctl_t'{OP_NOP,           SQ_COND,     C_ALWAYS,      A_EMIT};
      A_NDAY:     w = ctl_t'{OP_NOP,           SQ_COND,     C_DAY_FITS,    A_NDAY_INC};
      A_NDAY_CHK: w = ctl_t'{OP_NOP,           SQ_COND,     C_NM_BLOCK,    A_EMIT};
      A_NDAY_ADV: w = ctl_t'{OP_NM_DAY1,       SQ_CALL,     C_ALWAYS,      A_RECOMP};
      A_NDAY_END: w = ctl_t'{OP_NOP,           SQ_COND,     C_ALWAYS,      A_EMIT};
      A_NDAY_INC: w = ctl_t'{OP_DAY_INC,       SQ_COND,     C_ALWAYS,      A_EMIT};
      A_NMON:     w = ctl_t'{OP_NOP,           SQ_COND,     C_NM_BLOCK,    A_EMIT};
      A_NMON_GO:  w = ctl_t'{OP_NMONTH,        SQ_COND,     C_ALWAYS,      A_FIXUP};
      A_PMON:     w = ctl_t'{OP_NOP,           SQ_COND,     C_PM_BLOCK,    A_EMIT};
      A_PMON_GO:  w = ctl_t'{OP_PMONTH,        SQ_COND,     C_ALWAYS,      A_FIXUP};
      A_NYEAR:    w = ctl_t'{OP_NOP,           SQ_COND,     C_NY_BLOCK,    A_EMIT};
      A_NYEAR_GO: w = ctl_t'{OP_NYEAR,         SQ_NEXT,     C_ALWAYS,      A_FIXUP};
      A_FIXUP:    w = ctl_t'{OP_NOP,           SQ_CALL,     C_ALWAYS,      A_RECOMP};
      A_FIXUP_FD: w = ctl_t'{OP_FIX_DAY,       SQ_COND,     C_ALWAYS,      A_EMIT};
      A_SEL:      w = ctl_t'{OP_NOP,           SQ_COND,     C_CELL_OFF,    A_EMIT};
      A_SEL_CELL: w = ctl_t'{OP_CELL,          SQ_NEXT,     C_ALWAYS,      A_EMIT};
      A_SEL_BEF:  w = ctl_t'{OP_NOP,           SQ_COND,     C_CELL_BEFORE, A_SPREV};
      A_SEL_AFT:  w = ctl_t'{OP_NOP,           SQ_COND,     C_CELL_AFTER,  A_SNEXT};
      A_SEL_HERE: w = ctl_t'{OP_PICK_CELL,     SQ_COND,     C_ALWAYS,      A_EMIT};
      A_SPREV:    w = ctl_t'{OP_NOP,           SQ_COND,     C_PM_BLOCK,    A_EMIT};
      A_SPREV_MV: w = ctl_t'{OP_PMONTH,        SQ_CALL,     C_ALWAYS,      A_RECOMP};
      A_SPREV_FD: w = ctl_t'{OP_FIX_DAY,       SQ_NEXT,     C_ALWAYS,      A_EMIT};
      A_SPREV_PK: w = ctl_t'{OP_PICK_PREV,     SQ_COND,     C_ALWAYS,      A_EMIT};
      A_SNEXT:    w = ctl_t'{OP_NOP,           SQ_COND,     C_NM_BLOCK,    A_EMIT};
      A_SNEXT_PD: w = ctl_t'{OP_PICK_NEXT_DAY, SQ_NEXT,     C_ALWAYS,      A_EMIT};
      A_SNEXT_MV: w = ctl_t'{OP_NMONTH,        SQ_CALL,     C_ALWAYS,      A_RECOMP};
      A_SNEXT_FD: w = ctl_t'{OP_FIX_DAY,       SQ_NEXT,     C_ALWAYS,      A_EMIT};
      A_SNEXT_PK: w = ctl_t'{OP_PICK_YM,       SQ_COND,     C_ALWAYS,      A_EMIT};
      A_RECOMP:   w = ctl_t'{OP_WALK_INIT,     SQ_NEXT,     C_ALWAYS,      A_EMIT};
      A_WALK_Y:   w = ctl_t'{OP_YEAR_STEP,     SQ_COND,     C_YEAR_MORE,   A_WALK_Y};
      A_WALK_M:   w = ctl_t'{OP_MONTH_STEP,    SQ_COND,     C_MONTH_MORE,  A_WALK_M};
      A_FINISH:   w = ctl_t'{OP_FINISH,        SQ_RET,      C_ALWAYS,      A_EMIT};
      default:    w = ctl_t'{OP_NOP,           SQ_COND,     C_ALWAYS,      A_FETCH};
    endcase
    return w;
  endfunction

  addr_t pc;
  addr_t pc_next;
  addr_t ret;
  addr_t ret_next;
  addr_t disp;
  ctl_t  word;
  logic  hit;

  always_comb begin
    word = rom(pc);
    op   = word.op;
  end

  always_comb begin
    unique case (word.cond)
      C_ALWAYS:      hit = 1'b1;
      C_NO_ITEM:     hit = no_item;
      C_OUT_BLOCKED: hit = out_blocked;
      C_DAY_FITS:    hit = stat.day_fits;
      C_NM_BLOCK:    hit = stat.nm_block;
      C_PM_BLOCK:    hit = stat.pm_block;
      C_NY_BLOCK:    hit = stat.ny_block;
      C_CELL_OFF:    hit = stat.cell_off;
      C_CELL_BEFORE: hit = stat.cell_before;
      C_CELL_AFTER:  hit = stat.cell_after;
      C_YEAR_MORE:   hit = stat.year_more;
      C_MONTH_MORE:  hit = stat.month_more;
      default:       hit = 1'b0;
    endcase
  end

  always_comb begin
    unique case (kind)
      KIND_GOTO:   disp = A_GOTO;
      KIND_NDAY:   disp = A_NDAY;
      KIND_NMONTH: disp = A_NMON;
      KIND_PMONTH: disp = A_PMON;
      KIND_NYEAR:  disp = A_NYEAR;
      KIND_SELECT: disp = A_SEL;
      default:     disp = A_EMIT;
    endcase
  end

  always_comb begin
    ret_next = ret;
    unique case (word.mode)
      SQ_NEXT:     pc_next = pc + addr_t'(1);
      SQ_COND:     pc_next = hit ? word.target : pc + addr_t'(1);
      SQ_CALL: begin
        pc_next  = word.target;
        ret_next = pc + addr_t'(1);
      end
      SQ_RET:      pc_next = ret;
      SQ_DISPATCH: pc_next = disp;
      default:     pc_next = A_FETCH;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc  <= A_FETCH;
      ret <= A_EMIT;
    end else begin
      pc  <= pc_next;
      ret <= ret_next;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/mcn_dp.sv
// Calendar datapath: view and pick registers, command latch, grid cell math and date walk.
`timescale 1ns / 1ps
`default_nettype none

module mcn_dp import mcn_pkg::*; #(
  parameter int FIRST_YEAR = 1990,
  parameter int YEAR_SPAN  = 128
) (
  input  logic               clk,
  input  logic               rst,
  input  uop_t               op,
  input  logic               in_fire,
  input  logic [KIND_W-1:0]  in_kind,
  input  logic [YEAR_W-1:0]  in_year,
  input  logic [MONTH_W-1:0] in_month,
  input  logic [DAY_W-1:0]   in_day,
  input  logic [GRID_W-1:0]  in_row,
  input  logic [GRID_W-1:0]  in_column,
  output logic [KIND_W-1:0]  kind,
  output stat_t              stat,
  output res_t               res
);

  localparam int OFF_W     = (YEAR_SPAN > 1) ? $clog2(YEAR_SPAN) : 1;
  localparam int LAST_YEAR = FIRST_YEAR + YEAR_SPAN - 1;
  localparam int JAN1_P    = FIRST_YEAR - 1;
  localparam logic [WD_W-1:0] JAN1_WD =
    WD_W'((JAN1_P * 365 + JAN1_P / 4 - JAN1_P / 100 + JAN1_P / 400) % 7);
  localparam logic [OFF_W-1:0]      LAST_OFF = OFF_W'(YEAR_SPAN - 1);
  localparam logic [YEAR_SUM_W-1:0] BASE_Y   = YEAR_SUM_W'(FIRST_YEAR);
  localparam logic [YEAR_SUM_W-1:0] LAST_Y   = YEAR_SUM_W'(LAST_YEAR);
  localparam logic [1:0] M4_0   = 2'(FIRST_YEAR % 4);
  localparam logic [6:0] M100_0 = 7'(FIRST_YEAR % 100);
  localparam logic [8:0] M400_0 = 9'(FIRST_YEAR % 400);
  localparam logic [6:0] M100_LAST = 7'd99;
  localparam logic [8:0] M400_LAST = 9'd399;

  logic [OFF_W-1:0]   cur_off;
  logic [MONTH_W-1:0] cur_month;
  logic [DAY_W-1:0]   cur_day;
  logic [WD_W-1:0]    start_wd;
  logic [DAY_W-1:0]   dtm;
  logic [DAY_W-1:0]   dlm;
  logic [OFF_W-1:0]   pick_off;
  logic [MONTH_W-1:0] pick_month;
  logic [PDAY_W-1:0]  pick_day;

  logic [KIND_W-1:0]  c_kind;
  logic [YEAR_W-1:0]  c_year;
  logic [MONTH_W-1:0] c_month;
  logic [DAY_W-1:0]   c_day;
  logic [GRID_W-1:0]  c_row;
  logic [GRID_W-1:0]  c_column;
  logic               ok;
  logic signed [6:0]  grid_pos;

  logic [OFF_W-1:0]   w_off;
  logic [MONTH_W-1:0] w_month;
  logic [WD_W-1:0]    w_wd;
  logic [1:0]         w_m4;
  logic [6:0]         w_m100;
  logic [8:0]         w_m400;
  logic               w_leap;

  logic [YEAR_SUM_W-1:0] yr_ext;
  logic [YEAR_SUM_W-1:0] y_diff;
  logic                  y_ok;
  logic                  m_ok;
  logic                  d_ok;
  logic [OFF_W-1:0]      nm_off;
  logic [MONTH_W-1:0]    nm_month;
  logic [5:0]            rc_lin;
  logic signed [6:0]     cell_calc;
  logic [WD_W-1:0]       spill;
  logic [5:0]            trail;
  logic [5:0]            cell_u;
  logic [5:0]            dtm_ext;
  logic [YEAR_SUM_W-1:0] view_sum;
  logic [YEAR_SUM_W-1:0] pick_sum;

  always_comb begin
    yr_ext = {1'b0, c_year};
    y_diff = yr_ext - BASE_Y;
    y_ok   = (yr_ext >= BASE_Y) && (yr_ext <= LAST_Y);
    m_ok   = (c_month >= MONTH_JAN) && (c_month <= MONTH_DEC);
    d_ok   = (c_day != '0);
    if (cur_month >= MONTH_DEC) begin
      nm_off   = cur_off + OFF_W'(1);
      nm_month = MONTH_JAN;
    end else begin
      nm_off   = cur_off;
      nm_month = cur_month + MONTH_W'(1);
    end
    rc_lin    = {3'b000, c_row} * 6'd7 + {3'b000, c_column};
    cell_calc = $signed({1'b0, rc_lin}) - $signed({4'b0000, start_wd}) + 7'sd1;
    dtm_ext   = {1'b0, dtm};
    cell_u    = grid_pos[5:0];
    spill     = mod7(dtm_ext + {3'b000, start_wd});
    trail     = 6'd7 - {3'b000, spill};
    w_leap    = leap(w_m4, w_m100, w_m400);
    view_sum  = BASE_Y + YEAR_SUM_W'(cur_off);
    pick_sum  = BASE_Y + YEAR_SUM_W'(pick_off);
  end

  always_comb begin
    stat.day_fits    = ({1'b0, cur_day} + 6'd1) <= dtm_ext;
    stat.nm_block    = (cur_month >= MONTH_DEC) && (cur_off == LAST_OFF);
    stat.pm_block    = (cur_month <= MONTH_JAN) && (cur_off == '0);
    stat.ny_block    = (cur_off == LAST_OFF);
    stat.cell_off    = (c_row > ROW_LAST) || (c_column > COL_LAST);
    stat.cell_before = grid_pos[6] || (grid_pos == '0);
    stat.cell_after  = !stat.cell_before && (cell_u > dtm_ext) &&
                       ((cell_u - dtm_ext) <= trail);
    stat.year_more   = (w_off != cur_off);
    stat.month_more  = (w_month != cur_month);
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      c_kind   <= in_kind;
      c_year   <= in_year;
      c_month  <= in_month;
      c_day    <= in_day;
      c_row    <= in_row;
      c_column <= in_column;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_off    <= '0;
      cur_month  <= MONTH_JAN;
      cur_day    <= DAY_ONE;
      start_wd   <= JAN1_WD;
      dtm        <= LONG_MONTH;
      dlm        <= LONG_MONTH;
      pick_off   <= '0;
      pick_month <= MONTH_JAN;
      pick_day   <= PDAY_ONE;
    end else begin
      unique case (op)
        OP_GOTO: begin
          if (y_ok) cur_off <= y_diff[OFF_W-1:0];
          if (m_ok) cur_month <= c_month;
          if (d_ok) cur_day <= c_day;
        end
        OP_DAY_INC: cur_day <= cur_day + DAY_ONE;
        OP_NM_DAY1: begin
          cur_off   <= nm_off;
          cur_month <= nm_month;
          cur_day   <= DAY_ONE;
        end
        OP_NMONTH: begin
          cur_off   <= nm_off;
          cur_month <= nm_month;
        end
        OP_PMONTH: begin
          if (cur_month <= MONTH_JAN) begin
            cur_month <= MONTH_DEC;
            cur_off   <= cur_off - OFF_W'(1);
          end else begin
            cur_month <= cur_month - MONTH_W'(1);
          end
        end
        OP_NYEAR: cur_off <= cur_off + OFF_W'(1);
        OP_FIX_DAY: begin
          if (cur_day > dtm) cur_day <= DAY_ONE;
        end
        OP_FINISH: begin
          start_wd <= w_wd;
          dtm      <= mlen(cur_month, w_leap);
          dlm      <= (cur_month <= MONTH_JAN) ? LONG_MONTH :
                      mlen(cur_month - MONTH_W'(1), w_leap);
        end
        OP_PICK_CELL: begin
          pick_off   <= cur_off;
          pick_month <= cur_month;
          pick_day   <= cell_u;
        end
        OP_PICK_PREV: begin
          pick_off   <= cur_off;
          pick_month <= cur_month;
          pick_day   <= dtm_ext + cell_u;
        end
        OP_PICK_NEXT_DAY: pick_day <= cell_u - dtm_ext;
        OP_PICK_YM: begin
          pick_off   <= cur_off;
          pick_month <= cur_month;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (op) inside
      OP_FETCH: ok <= 1'b0;
      OP_GOTO:  ok <= y_ok || m_ok || d_ok;
      OP_DAY_INC, OP_NM_DAY1, OP_NMONTH, OP_PMONTH, OP_NYEAR, OP_PICK_CELL: ok <= 1'b1;
      OP_CELL:  grid_pos <= cell_calc;
      OP_WALK_INIT: begin
        w_off   <= '0;
        w_month <= MONTH_JAN;
        w_wd    <= JAN1_WD;
        w_m4    <= M4_0;
        w_m100  <= M100_0;
        w_m400  <= M400_0;
      end
      OP_YEAR_STEP: begin
        if (stat.year_more) begin
          w_wd   <= mod7({3'b000, w_wd} + 6'd1 + {5'b00000, w_leap});
          w_off  <= w_off + OFF_W'(1);
          w_m4   <= w_m4 + 2'd1;
          w_m100 <= (w_m100 == M100_LAST) ? 7'd0 : w_m100 + 7'd1;
          w_m400 <= (w_m400 == M400_LAST) ? 9'd0 : w_m400 + 9'd1;
        end
      end
      OP_MONTH_STEP: begin
        if (stat.month_more) begin
          w_wd    <= mod7({3'b000, w_wd} + {1'b0, mlen(w_month, w_leap)});
          w_month <= w_month + MONTH_W'(1);
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    kind                   = c_kind;
    res.accepted           = ok;
    res.view_year          = view_sum[YEAR_W-1:0];
    res.view_month         = cur_month;
    res.view_day           = cur_day;
    res.first_weekday      = start_wd;
    res.month_length       = dtm;
    res.prior_month_length = dlm;
    res.chosen_year        = pick_sum[YEAR_W-1:0];
    res.chosen_month       = pick_month;
    res.chosen_day         = pick_day;
  end

endmodule

`default_nettype wire

FILE: hdl/mcn_checker.sv
// Port-level checker for the month calendar navigator and its bind to the top level.
`timescale 1ns / 1ps
`default_nettype none

module mcn_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [55:0] m_tdata,
  input logic [0:0]  m_tuser
);

  a_one_item_at_a_time: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("command taken while the previous one is still running");

  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled result changed or dropped");

  a_reset_empties: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid after reset");

  a_layout_sane: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[15:12] != 4'd0 && m_tdata[15:12] <= 4'd12 &&
                 m_tdata[23:21] != 3'd7 &&
                 m_tdata[28:24] >= 5'd28 && m_tdata[28:24] <= 5'd31 &&
                 m_tdata[33:29] >= 5'd28 && m_tdata[33:29] <= 5'd31)
    else $error("month layout out of range");

endmodule

bind month_calendar_navigator_core mcn_checker u_mcn_checker (.*);

`default_nettype wire
